// ===== sv/u2l_pkg.sv =====
// ----------------------------------------------------------------------------
// u2l_pkg
// Shared types and constants of the UTF-8 to Latin-1 escaping decoder.
// ----------------------------------------------------------------------------
package u2l_pkg;

  // Bytes of a pending multi-byte sequence that can be held.
  localparam int unsigned HELD_DEPTH = 6;

  // Kinds of work handed from the front end to the back end.
  localparam logic [1:0] KIND_CHAR = 2'd0;  // one raw character
  localparam logic [1:0] KIND_ESC  = 2'd1;  // backslash and a letter
  localparam logic [1:0] KIND_HEX  = 2'd2;  // a list of bytes, each as \xNN

  // Characters used by the escapes.
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_X      = 8'h78;

  // One queue word: the characters that one input byte causes.
  typedef struct packed {
    logic [1:0]                       kind;
    logic [7:0]                       ch;
    logic [HELD_DEPTH-1:0][7:0]       bytes;
    logic [2:0]                       count;
  } entry_t;

  // Lowercase hex digit of a nibble.
  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [7:0] d;
    if (n < 4'd10) begin
      d = 8'h30 + {4'd0, n};
    end else begin
      d = 8'h57 + {4'd0, n};
    end
    return d;
  endfunction

endpackage

// ===== sv/u2l_front.sv =====
// ----------------------------------------------------------------------------
// u2l_front
// Accepts input bytes, tracks the UTF-8 sequence state and classifies each
// byte into at most one queue word describing the characters it produces.
// ----------------------------------------------------------------------------
module u2l_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  input  logic             string_start,
  input  logic             cfg_valid,
  input  logic [7:0]       cfg_data,
  input  logic             q_full,
  output logic             q_push,
  output u2l_pkg::entry_t  q_entry
);

  logic [7:0]  delimiter;
  logic [2:0]  bytes_left;
  logic [2:0]  held_count;
  logic [30:0] code_value;
  logic        resyncing;
  logic [7:0]  held [u2l_pkg::HELD_DEPTH];

  logic [2:0]  bytes_left_next;
  logic [2:0]  held_count_next;
  logic [30:0] code_value_next;
  logic        resyncing_next;
  logic        held_we;
  logic [2:0]  held_idx;

  logic [2:0]  bl;
  logic [2:0]  hc;
  logic [30:0] cv;
  logic        rs;
  logic        accept;
  logic        has_out;
  logic        esc_needed;
  logic [30:0] cv_cont;
  logic [2:0]  bl_dec;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && has_out;

  // A new string drops whatever was pending before this byte is handled.
  assign bl = string_start ? 3'd0 : bytes_left;
  assign hc = string_start ? 3'd0 : held_count;
  assign cv = string_start ? 31'd0 : code_value;
  assign rs = string_start ? 1'b0 : resyncing;

  assign cv_cont = {cv[24:0], in_byte[5:0]};
  assign bl_dec  = bl - 3'd1;

  assign esc_needed = (in_byte < 8'h20) || (in_byte == 8'h7f) || (in_byte == delimiter) ||
                      ((delimiter != 8'h00) && (in_byte == u2l_pkg::CH_BSLASH));

  // Classification of the incoming byte and the next sequence state.
  always_comb begin
    bytes_left_next = bl;
    held_count_next = hc;
    code_value_next = cv;
    resyncing_next  = rs;
    held_we         = 1'b0;
    held_idx        = hc;
    has_out         = 1'b0;
    q_entry.kind    = u2l_pkg::KIND_HEX;
    q_entry.ch      = in_byte;
    q_entry.count   = 3'd1;
    for (int i = 0; i < u2l_pkg::HELD_DEPTH; i++) begin
      q_entry.bytes[i] = (i[2:0] == hc) ? in_byte : held[i];
    end

    if (rs && !((in_byte < 8'h80) || (in_byte inside {[8'hc0:8'hfd]}))) begin
      // Still resynchronising: the byte is written as a hex escape.
      has_out          = 1'b1;
      q_entry.bytes[0] = in_byte;
    end else begin
      resyncing_next = 1'b0;
      if (bl == 3'd0) begin
        if (in_byte < 8'h80) begin
          has_out = 1'b1;
          if (esc_needed) begin
            q_entry.bytes[0] = in_byte;
            q_entry.kind     = u2l_pkg::KIND_ESC;
            case (in_byte)
              8'h0a:   q_entry.ch = 8'h6e;
              8'h0d:   q_entry.ch = 8'h72;
              8'h0c:   q_entry.ch = 8'h66;
              8'h0b:   q_entry.ch = 8'h76;
              8'h08:   q_entry.ch = 8'h62;
              8'h00:   q_entry.ch = 8'h30;
              default: q_entry.kind = u2l_pkg::KIND_HEX;
            endcase
          end else begin
            q_entry.kind = u2l_pkg::KIND_CHAR;
          end
        end else if (in_byte inside {[8'hc0:8'hfd]}) begin
          // Lead byte of a multi-byte sequence.
          held_we         = 1'b1;
          held_idx        = 3'd0;
          held_count_next = 3'd1;
          if (in_byte[7:5] == 3'b110) begin
            code_value_next = {26'd0, in_byte[4:0]};
            bytes_left_next = 3'd1;
          end else if (in_byte[7:4] == 4'b1110) begin
            code_value_next = {27'd0, in_byte[3:0]};
            bytes_left_next = 3'd2;
          end else if (in_byte[7:3] == 5'b11110) begin
            code_value_next = {28'd0, in_byte[2:0]};
            bytes_left_next = 3'd3;
          end else if (in_byte[7:2] == 6'b111110) begin
            code_value_next = {29'd0, in_byte[1:0]};
            bytes_left_next = 3'd4;
          end else begin
            code_value_next = {30'd0, in_byte[0]};
            bytes_left_next = 3'd5;
          end
        end else begin
          // Stray continuation or an unused lead code.
          has_out          = 1'b1;
          q_entry.bytes[0] = in_byte;
          resyncing_next   = 1'b1;
        end
      end else if ((in_byte < 8'h80) || (in_byte >= 8'hc0)) begin
        // Broken sequence: flush the held bytes and this one.
        has_out         = 1'b1;
        q_entry.count   = hc + 3'd1;
        bytes_left_next = 3'd0;
        held_count_next = 3'd0;
        resyncing_next  = 1'b1;
      end else begin
        // Continuation byte.
        held_we         = (hc < 3'(u2l_pkg::HELD_DEPTH));
        held_count_next = hc + 3'd1;
        code_value_next = cv_cont;
        bytes_left_next = bl_dec;
        if (bl_dec == 3'd0) begin
          has_out         = 1'b1;
          held_count_next = 3'd0;
          if ((cv_cont[30:8] == 23'd0) && cv_cont[7]) begin
            q_entry.kind = u2l_pkg::KIND_CHAR;
            q_entry.ch   = cv_cont[7:0];
          end else begin
            q_entry.count = hc + 3'd1;
          end
        end
      end
    end
  end

  // Control state and the delimiter register.
  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter  <= 8'h00;
      bytes_left <= 3'd0;
      held_count <= 3'd0;
      code_value <= 31'd0;
      resyncing  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        delimiter <= cfg_data;
      end
      if (accept) begin
        bytes_left <= bytes_left_next;
        held_count <= held_count_next;
        code_value <= code_value_next;
        resyncing  <= resyncing_next;
      end
    end
  end

  // Held sequence bytes need no reset.
  always_ff @(posedge clk) begin
    if (accept && held_we) begin
      held[held_idx] <= in_byte;
    end
  end

endmodule

// ===== sv/u2l_queue.sv =====
// ----------------------------------------------------------------------------
// u2l_queue
// Two-word queue between the front end and the back end.
// ----------------------------------------------------------------------------
module u2l_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  u2l_pkg::entry_t  push_entry,
  input  logic             pop,
  output u2l_pkg::entry_t  head,
  output logic             empty,
  output logic             full
);

  u2l_pkg::entry_t words [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);
  assign head  = words[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      words[wr_ptr] <= push_entry;
    end
  end

endmodule

// ===== sv/u2l_back.sv =====
// ----------------------------------------------------------------------------
// u2l_back
// Expands the queue word at the head into output characters, one a cycle unless
// the output stage is held, into a registered output stage.
// ----------------------------------------------------------------------------
module u2l_back (
  input  logic             clk,
  input  logic             rst,
  input  u2l_pkg::entry_t  head,
  input  logic             empty,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_char,
  output logic             last_of_run
);

  logic [2:0] pos;
  logic [1:0] phase;
  logic       fire;
  logic       last;
  logic [7:0] ch;
  logic [7:0] cur_byte;

  assign fire     = !empty && (!out_valid || out_ready);
  assign pop      = fire && last;
  assign cur_byte = head.bytes[pos];

  // Character selection for the current position in the word.
  always_comb begin
    ch   = head.ch;
    last = 1'b1;
    case (head.kind)
      u2l_pkg::KIND_CHAR: begin
        ch   = head.ch;
        last = 1'b1;
      end
      u2l_pkg::KIND_ESC: begin
        ch   = (phase == 2'd0) ? u2l_pkg::CH_BSLASH : head.ch;
        last = (phase == 2'd1);
      end
      u2l_pkg::KIND_HEX: begin
        case (phase)
          2'd0:    ch = u2l_pkg::CH_BSLASH;
          2'd1:    ch = u2l_pkg::CH_X;
          2'd2:    ch = u2l_pkg::hex_digit(cur_byte[7:4]);
          default: ch = u2l_pkg::hex_digit(cur_byte[3:0]);
        endcase
        last = (phase == 2'd3) && (pos == head.count - 3'd1);
      end
      default: begin
        ch   = head.ch;
        last = 1'b1;
      end
    endcase
  end

  // Position counters and the output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= 3'd0;
      phase     <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
        if (last) begin
          pos   <= 3'd0;
          phase <= 2'd0;
        end else if (phase == 2'd3) begin
          pos   <= pos + 3'd1;
          phase <= 2'd0;
        end else begin
          phase <= phase + 2'd1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (fire) begin
      out_char    <= ch;
      last_of_run <= last;
    end
  end

endmodule

// ===== sv/utf8_to_latin1_escaping_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_to_latin1_escaping_decoder
// Decodes a UTF-8 byte stream into Latin-1 characters with escapes.
// ----------------------------------------------------------------------------
// The first character of a byte goes through the queue and then the registered output stage.
// The back end gives one character a cycle while its output is not held: a raw byte gives one,
// a named escape two, and a hex list four per byte (up to 24 for a broken sequence).
// The input stalls only when the two-word queue ahead of the back end is full.
// Reset is synchronous: it clears sequence state, the delimiter, queue and output
// valid; the held sequence bytes are not cleared.
module utf8_to_latin1_escaping_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       string_start,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       last_of_run,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  u2l_pkg::entry_t push_entry;
  u2l_pkg::entry_t head;
  logic            q_push;
  logic            q_pop;
  logic            q_empty;
  logic            q_full;

  assign cfg_ready = 1'b1;

  u2l_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .string_start (string_start),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (push_entry)
  );

  u2l_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .head       (head),
    .empty      (q_empty),
    .full       (q_full)
  );

  u2l_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .empty       (q_empty),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_char    (out_char),
    .last_of_run (last_of_run)
  );

  // The queue is never written while full.
  assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("queue written while full");

  // A word is only retired from a non-empty queue.
  assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("queue read while empty");

  // Retiring a word leaves its final character in the output stage.
  assert property (@(posedge clk) disable iff (rst) q_pop |=> (out_valid && last_of_run))
    else $error("word retired without its final character");

endmodule

// ===== tb/latin1_stream_checker.sv =====
// ----------------------------------------------------------------------------
// latin1_stream_checker
// Watches the byte, character and delimiter channels of the escaping decoder.
// It decodes every accepted byte itself, queues the characters that the byte
// should cause, and compares each accepted character word against them.
// ----------------------------------------------------------------------------
module latin1_stream_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       string_start,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_char,
  input  logic       last_of_run,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [7:0] cfg_data,
  output int         fail_count,
  output int         backlog
);

  // Shared constants of the decoder.
  localparam int unsigned HELD_DEPTH = u2l_pkg::HELD_DEPTH;
  localparam logic [7:0]  CH_BSLASH  = u2l_pkg::CH_BSLASH;
  localparam logic [7:0]  CH_X       = u2l_pkg::CH_X;

  // Letters of the named escapes.
  localparam logic [7:0] LETTER_N    = "n";
  localparam logic [7:0] LETTER_R    = "r";
  localparam logic [7:0] LETTER_F    = "f";
  localparam logic [7:0] LETTER_V    = "v";
  localparam logic [7:0] LETTER_B    = "b";
  localparam logic [7:0] LETTER_ZERO = "0";

  // Control characters that have a named escape.
  localparam logic [7:0] CTRL_NUL = 8'h00;
  localparam logic [7:0] CTRL_BS  = 8'h08;
  localparam logic [7:0] CTRL_LF  = 8'h0a;
  localparam logic [7:0] CTRL_VT  = 8'h0b;
  localparam logic [7:0] CTRL_FF  = 8'h0c;
  localparam logic [7:0] CTRL_CR  = 8'h0d;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_word_t;

  // Expected characters, oldest first.
  char_word_t expected_chars[$];
  // Characters caused by the byte being decoded.
  logic [7:0] run_chars[$];

  // Decoder state.
  logic [7:0]  delim;
  logic [2:0]  seq_remaining;
  logic [2:0]  seq_len;
  logic [7:0]  seq_bytes[HELD_DEPTH];
  logic [30:0] seq_code;
  logic        in_resync;

  function automatic logic [7:0] nibble_char(input logic [3:0] n);
    if (n < 4'd10) begin
      return 8'h30 + {4'd0, n};
    end
    return 8'h61 + {4'd0, n} - 8'd10;
  endfunction

  function automatic void put_hex(input logic [7:0] b);
    run_chars.push_back(CH_BSLASH);
    run_chars.push_back(CH_X);
    run_chars.push_back(nibble_char(b[7:4]));
    run_chars.push_back(nibble_char(b[3:0]));
  endfunction

  function automatic void flush_held();
    for (int i = 0; i < int'(seq_len) && i < HELD_DEPTH; i++) begin
      put_hex(seq_bytes[i]);
    end
  endfunction

  // A plain ASCII byte: pass it through or escape it.
  function automatic void put_ascii(input logic [7:0] b);
    if (b < 8'h20 || b == 8'h7f || b == delim || (delim != 8'h00 && b == CH_BSLASH)) begin
      case (b)
        CTRL_LF:  begin run_chars.push_back(CH_BSLASH); run_chars.push_back(LETTER_N); end
        CTRL_CR:  begin run_chars.push_back(CH_BSLASH); run_chars.push_back(LETTER_R); end
        CTRL_FF:  begin run_chars.push_back(CH_BSLASH); run_chars.push_back(LETTER_F); end
        CTRL_VT:  begin run_chars.push_back(CH_BSLASH); run_chars.push_back(LETTER_V); end
        CTRL_BS:  begin run_chars.push_back(CH_BSLASH); run_chars.push_back(LETTER_B); end
        CTRL_NUL: begin run_chars.push_back(CH_BSLASH); run_chars.push_back(LETTER_ZERO); end
        default:  put_hex(b);
      endcase
    end else begin
      run_chars.push_back(b);
    end
  endfunction

  function automatic void open_seq(input logic [7:0] b, input logic [30:0] payload,
                                   input logic [2:0] more);
    seq_bytes[0]  = b;
    seq_len       = 3'd1;
    seq_code      = payload;
    seq_remaining = more;
  endfunction

  // Works out the characters that one accepted byte causes and queues them.
  function automatic void decode_byte(input logic [7:0] b, input logic first_of_string);
    logic skip;
    skip = 1'b0;
    run_chars.delete();
    if (first_of_string) begin
      seq_remaining = 3'd0;
      seq_len       = 3'd0;
      seq_code      = '0;
      in_resync     = 1'b0;
    end
    // While resynchronising, continuation and invalid bytes are escaped.
    if (in_resync) begin
      if (!(b < 8'h80 || (b >= 8'hc0 && b <= 8'hfd))) begin
        put_hex(b);
        skip = 1'b1;
      end else begin
        in_resync = 1'b0;
      end
    end
    if (!skip) begin
      if (seq_remaining == 3'd0) begin
        if (b < 8'h80) begin
          put_ascii(b);
        end else if (b[7:5] == 3'b110) begin
          open_seq(b, {26'd0, b[4:0]}, 3'd1);
        end else if (b[7:4] == 4'b1110) begin
          open_seq(b, {27'd0, b[3:0]}, 3'd2);
        end else if (b[7:3] == 5'b11110) begin
          open_seq(b, {28'd0, b[2:0]}, 3'd3);
        end else if (b[7:2] == 6'b111110) begin
          open_seq(b, {29'd0, b[1:0]}, 3'd4);
        end else if (b[7:1] == 7'b1111110) begin
          open_seq(b, {30'd0, b[0]}, 3'd5);
        end else begin
          put_hex(b);
          in_resync = 1'b1;
        end
      end else if (b[7:6] != 2'b10) begin
        // Broken sequence: everything held comes out escaped.
        flush_held();
        put_hex(b);
        seq_remaining = 3'd0;
        seq_len       = 3'd0;
        in_resync     = 1'b1;
      end else begin
        if (seq_len < 3'(HELD_DEPTH)) begin
          seq_bytes[seq_len] = b;
          seq_len = seq_len + 3'd1;
        end
        seq_code      = {seq_code[24:0], b[5:0]};
        seq_remaining = seq_remaining - 3'd1;
        if (seq_remaining == 3'd0) begin
          if (seq_code >= 31'h80 && seq_code < 31'h100) begin
            run_chars.push_back(seq_code[7:0]);
          end else begin
            flush_held();
          end
          seq_len = 3'd0;
        end
      end
    end
    foreach (run_chars[i]) begin
      expected_chars.push_back('{ch: run_chars[i], last: (i == run_chars.size() - 1)});
    end
  endfunction

  // Predict on accepted bytes, compare on accepted characters.
  always @(posedge clk) begin
    char_word_t want;
    if (rst) begin
      delim         = 8'h00;
      seq_remaining = 3'd0;
      seq_len       = 3'd0;
      seq_code      = '0;
      in_resync     = 1'b0;
      fail_count    = 0;
      expected_chars.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        delim = cfg_data;
      end
      if (in_valid && in_ready) begin
        decode_byte(in_byte, string_start);
      end
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected word: expected none, actual out_char %h last_of_run %b",
                   $time, out_char, last_of_run);
          fail_count++;
        end else begin
          want = expected_chars.pop_front();
          if (out_char !== want.ch) begin
            $display("%0t: out_char mismatch: expected %h, actual %h",
                     $time, want.ch, out_char);
            fail_count++;
          end
          if (last_of_run !== want.last) begin
            $display("%0t: last_of_run mismatch: expected %b, actual %b",
                     $time, want.last, last_of_run);
            fail_count++;
          end
        end
      end
    end
    backlog = expected_chars.size();
  end

endmodule

// ===== tb/tb_utf8_to_latin1_escaping_decoder.sv =====
// ----------------------------------------------------------------------------
// tb_utf8_to_latin1_escaping_decoder
// Drives directed and random UTF-8 text through the escaping decoder under
// several delimiter settings, with random stalls on both sides and a long
// receiver hold-off. A checker beside the block predicts every character.
// ----------------------------------------------------------------------------
module tb_utf8_to_latin1_escaping_decoder;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 150;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       string_start;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_char;
  logic       last_of_run;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_data;

  int fail_count;
  int backlog;
  int quiet_cycles;

  bit tx_idle_on;
  bit rx_idle_on;
  bit hold_request;
  bit hold_taken;

  utf8_to_latin1_escaping_decoder dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .string_start (string_start),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char     (out_char),
    .last_of_run  (last_of_run),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  latin1_stream_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .string_start (string_start),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char     (out_char),
    .last_of_run  (last_of_run),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .backlog      (backlog)
  );

  // Clock.
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Watchdog: ends the run when nothing has been accepted for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("utf8_to_latin1_escaping_decoder regression: fail");
        $finish;
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    out_ready  = 1'b0;
    hold_taken = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= rx_idle_on ? ($urandom_range(99) >= 24) : 1'b1;
    end
  end

  // Offers one byte and returns at the edge where it is taken.
  task automatic send_byte(input logic [7:0] b, input logic s);
    @(negedge clk);
    while (tx_idle_on && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_byte      <= b;
    string_start <= s;
    do @(posedge clk); while (!in_ready);
  endtask

  // Lets every expected word drain, then writes the delimiter.
  task automatic set_delimiter(input logic [7:0] d);
    @(negedge clk);
    in_valid <= 1'b0;
    while (backlog != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // A random lead byte for a sequence of len bytes.
  function automatic logic [7:0] lead_byte(input int len);
    logic [7:0] r;
    r = 8'($urandom);
    case (len)
      2:       return {3'b110, r[4:0]};
      3:       return {4'b1110, r[3:0]};
      4:       return {5'b11110, r[2:0]};
      5:       return {6'b111110, r[1:0]};
      default: return {7'b1111110, r[0]};
    endcase
  endfunction

  // Random text: mostly well-formed sequences, some broken ones and noise.
  task automatic send_random_text(input int count);
    int         sent;
    int         pick;
    int         len;
    logic       fresh;
    logic [7:0] cp;
    logic [7:0] seq[$];
    sent = 0;
    while (sent < count) begin
      seq.delete();
      pick = $urandom_range(99);
      if (pick < 35) begin
        seq.push_back(8'($urandom_range(127)));
      end else if (pick < 65) begin
        cp = 8'($urandom_range(255, 128));
        seq.push_back({6'b110000, cp[7:6]});
        seq.push_back({2'b10, cp[5:0]});
      end else if (pick < 85) begin
        len = $urandom_range(6, 2);
        seq.push_back(lead_byte(len));
        repeat (len - 1) seq.push_back({2'b10, 6'($urandom)});
      end else if (pick < 95) begin
        len = $urandom_range(6, 2);
        seq.push_back(lead_byte(len));
        repeat ($urandom_range(len - 2)) seq.push_back({2'b10, 6'($urandom)});
        cp = 8'($urandom);
        if (cp[7:6] == 2'b10) begin
          cp[6] = 1'b1;
        end
        seq.push_back(cp);
      end else begin
        seq.push_back(8'($urandom));
      end
      fresh = ($urandom_range(15) == 0);
      foreach (seq[i]) begin
        send_byte(seq[i], fresh && i == 0);
      end
      sent += seq.size();
    end
  endtask

  // Stimulus and verdict.
  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    in_byte      = 8'h00;
    string_start = 1'b0;
    cfg_valid    = 1'b0;
    cfg_data     = 8'h00;
    tx_idle_on   = 1'b1;
    rx_idle_on   = 1'b1;
    hold_request = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Plain, escaped and named-escape ASCII with the delimiter off.
    send_byte(8'h41, 1'b1); send_byte(8'h20, 1'b0); send_byte(8'h7e, 1'b0);
    send_byte(8'h7f, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h0a, 1'b0);
    send_byte(8'h0d, 1'b0); send_byte(8'h0c, 1'b0); send_byte(8'h0b, 1'b0);
    send_byte(8'h08, 1'b0); send_byte(8'h1f, 1'b0); send_byte(8'h5c, 1'b0);
    // Two-byte codes at both ends of the Latin-1 range, and an overlong one.
    send_byte(8'hc2, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hc3, 1'b0); send_byte(8'hbf, 1'b0);
    send_byte(8'hc1, 1'b0); send_byte(8'h81, 1'b0);
    // A three-byte code out of range.
    send_byte(8'he2, 1'b0); send_byte(8'h82, 1'b0); send_byte(8'hac, 1'b0);
    // Stray bytes, resync held by a continuation byte, left by ASCII.
    send_byte(8'h80, 1'b0); send_byte(8'hbf, 1'b0); send_byte(8'h61, 1'b0);
    send_byte(8'hfe, 1'b0); send_byte(8'hff, 1'b0);
    // Longest broken sequence: five held bytes and the breaker.
    send_byte(8'hfc, 1'b1); send_byte(8'hbf, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hbf, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'h7f, 1'b0);
    // A new string drops a pending sequence silently.
    send_byte(8'he2, 1'b1); send_byte(8'h82, 1'b0); send_byte(8'h62, 1'b1);

    // Quote as delimiter: quote and backslash are escaped.
    set_delimiter(8'h22);
    send_byte(8'h22, 1'b1); send_byte(8'h5c, 1'b0); send_byte(8'h78, 1'b0);
    // A high delimiter never matches, but backslash is still escaped.
    set_delimiter(8'hff);
    send_byte(8'h5c, 1'b1); send_byte(8'h22, 1'b0);
    send_byte(8'hc3, 1'b0); send_byte(8'hbf, 1'b0);

    // Random text with a long receiver hold-off at the start.
    set_delimiter(8'($urandom_range(126, 33)));
    hold_request = 1'b1;
    send_random_text(70);

    // A long stretch with no idling on either side.
    set_delimiter(8'h00);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_random_text(70);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;

    set_delimiter(8'hff);
    send_random_text(60);

    set_delimiter(8'($urandom));
    send_random_text(60);

    // Drain and settle.
    @(negedge clk);
    in_valid <= 1'b0;
    while (backlog != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0 && backlog == 0) begin
      $display("utf8_to_latin1_escaping_decoder regression: pass");
    end else begin
      $display("utf8_to_latin1_escaping_decoder regression: fail");
    end
    $finish;
  end

endmodule
